// File: rtl/mse_pkg.sv
// Shared types and sizes for the maximum-subarray extractor.
`default_nettype none
package mse_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int VAL_W     = 32;
    localparam int SUM_W     = 38;
    localparam int OUT_SUM_W = 37;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    last;
    } in_request_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] element;
        logic [OUT_SUM_W-1:0]    best_sum;
        logic                    overflowed;
        logic                    run_end;
    } out_request_t;

    // Final figures of a sequence, valid in the cycle its last request is accepted.
    typedef struct packed {
        logic [IDX_W-1:0]     best_start;
        logic [IDX_W-1:0]     best_end;
        logic [OUT_SUM_W-1:0] best_sum;
        logic                 overflowed;
    } seq_result_t;

endpackage
`default_nettype wire

// File: rtl/max_subarray_extract_top.sv
// Top level of the maximum-subarray extractor: element store, scan and emission.
`default_nettype none
// The block takes a sequence of signed 32-bit requests, one per cycle while
// it is scanning, and keeps a Kadane running sum as they arrive; each value
// is also written into a 64-entry synchronous store. The request marked last
// closes the sequence: the block then stops taking input and reads the best
// run back out of the store, one element per cycle while the output side
// keeps taking them; each element passes through the store's read register
// before it shows. The best sum is the first run to reach the maximum; if
// no sum was positive only the first element is sent, with a best sum of zero.
// Requests beyond the store depth are dropped and reported on the overflowed
// field of that sequence's results. Input is taken again as soon as the read
// of the final element has been issued, even while that element still waits
// at the output. Reset needs no clearing pass: a run never touches an entry
// that the current sequence did not write.
module max_subarray_extract_top (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire mse_pkg::in_request_t  s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output mse_pkg::out_request_t      m_data
);
    import mse_pkg::*;

    typedef enum logic [1:0] {
        ST_SCAN = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic                  s_accept;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    seq_result_t           result;

    logic [VAL_W-1:0]      store_mem [MAX_ITEMS];
    logic [VAL_W-1:0]      rdata_reg;

    logic [IDX_W-1:0]      rd_ptr_reg;
    logic [IDX_W-1:0]      end_reg;
    logic [OUT_SUM_W-1:0]  sum_reg;
    logic                  ovf_reg;

    logic                  m_valid_reg, m_valid_next;
    logic [OUT_SUM_W-1:0]  o_sum_reg;
    logic                  o_ovf_reg;
    logic                  o_end_reg;

    logic                  advance;
    logic                  issue;
    logic                  final_read;

    assign s_ready  = (state_reg == ST_SCAN);
    assign s_accept = s_valid && s_ready;

    mse_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (s_accept),
        .req     (s_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .result  (result)
    );

    // The store's read register doubles as the output register: it only
    // loads when the output slot is empty or being taken.
    assign advance    = !m_valid_reg || m_ready;
    assign issue      = (state_reg == ST_EMIT) && advance;
    assign final_read = (rd_ptr_reg == end_reg);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr] <= s_data.value;
        end
        if (issue) begin
            rdata_reg <= store_mem[rd_ptr_reg];
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_SCAN: begin
                if (s_accept && s_data.last) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (issue && final_read) begin
                    state_next = ST_SCAN;
                end
            end
            default: state_next = ST_SCAN;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = issue;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_SCAN;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Run bounds and tags of the sequence being sent out.
    always_ff @(posedge aclk) begin
        if (s_accept && s_data.last) begin
            rd_ptr_reg <= result.best_start;
            end_reg    <= result.best_end;
            sum_reg    <= result.best_sum;
            ovf_reg    <= result.overflowed;
        end else if (issue) begin
            rd_ptr_reg <= rd_ptr_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            o_sum_reg <= sum_reg;
            o_ovf_reg <= ovf_reg;
            o_end_reg <= final_read;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_data.element    = rdata_reg;
    assign m_data.best_sum   = o_sum_reg;
    assign m_data.overflowed = o_ovf_reg;
    assign m_data.run_end    = o_end_reg;

    a_last_starts_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_data.last) |=> (state_reg == ST_EMIT))
        else $error("last request did not start emission");
    a_ptr_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (rd_ptr_reg <= end_reg))
        else $error("read pointer ran past the end of the best run");
    a_issue_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        issue |=> m_valid_reg)
        else $error("issued read did not reach the output");

endmodule
`default_nettype wire

// File: rtl/mse_scan.sv
// Kadane scan registers: running sum, best run and item count of one sequence.
`default_nettype none
module mse_scan (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  accept,
    input  wire mse_pkg::in_request_t  req,
    output logic                       wr_en,
    output logic [mse_pkg::IDX_W-1:0]  wr_addr,
    output mse_pkg::seq_result_t       result
);
    import mse_pkg::*;

    logic [CNT_W-1:0]        item_count_reg, item_count_next;
    logic signed [SUM_W-1:0] running_sum_reg, running_sum_next;
    logic signed [SUM_W-1:0] best_total_reg, best_total_next;
    logic [CNT_W-1:0]        cand_start_reg, cand_start_next;
    logic [IDX_W-1:0]        best_start_reg, best_start_next;
    logic [IDX_W-1:0]        best_end_reg, best_end_next;
    logic                    overflow_reg, overflow_next;
    logic                    full;
    logic signed [SUM_W-1:0] sum_add;

    assign full    = (item_count_reg == CNT_W'(MAX_ITEMS));
    assign sum_add = running_sum_reg + {{(SUM_W-VAL_W){req.value[VAL_W-1]}}, req.value};
    assign wr_en   = accept && !full;
    assign wr_addr = item_count_reg[IDX_W-1:0];

    always_comb begin
        item_count_next  = item_count_reg;
        running_sum_next = running_sum_reg;
        best_total_next  = best_total_reg;
        cand_start_next  = cand_start_reg;
        best_start_next  = best_start_reg;
        best_end_next    = best_end_reg;
        overflow_next    = overflow_reg;
        if (!full) begin
            running_sum_next = sum_add;
            if (sum_add[SUM_W-1]) begin
                // A negative sum can never help a later run: restart after this item.
                running_sum_next = '0;
                cand_start_next  = item_count_reg + CNT_W'(1);
            end
            if (best_total_reg < running_sum_next) begin
                best_total_next = running_sum_next;
                best_start_next = cand_start_next[IDX_W-1:0];
                best_end_next   = item_count_reg[IDX_W-1:0];
            end
            item_count_next = item_count_reg + CNT_W'(1);
        end else begin
            overflow_next = 1'b1;
        end
    end

    assign result.best_start = best_start_next;
    assign result.best_end   = best_end_next;
    assign result.best_sum   = best_total_next[OUT_SUM_W-1:0];
    assign result.overflowed = overflow_next;

    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && req.last)) begin
            item_count_reg  <= '0;
            running_sum_reg <= '0;
            best_total_reg  <= '0;
            cand_start_reg  <= '0;
            best_start_reg  <= '0;
            best_end_reg    <= '0;
            overflow_reg    <= 1'b0;
        end else if (accept) begin
            item_count_reg  <= item_count_next;
            running_sum_reg <= running_sum_next;
            best_total_reg  <= best_total_next;
            cand_start_reg  <= cand_start_next;
            best_start_reg  <= best_start_next;
            best_end_reg    <= best_end_next;
            overflow_reg    <= overflow_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        item_count_reg <= CNT_W'(MAX_ITEMS))
        else $error("item count beyond store depth");
    a_run_order: assert property (@(posedge aclk) disable iff (!aresetn)
        best_start_reg <= best_end_reg)
        else $error("best run starts after it ends");
    a_sum_nonneg: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !running_sum_reg[SUM_W-1])
        else $error("running sum went negative");

endmodule
`default_nettype wire
